>>> rtl/tplc_pkg.sv
// Shared types and constants for the two-point linear calibration block.
// No dependencies; used by tplc_coef, two_point_linear_calibration and the testbench.
package tplc_pkg;

	localparam int DATA_W           = 32;
	localparam int FRAC_W           = 18;
	localparam int ADDR_W           = 4;
	localparam int SAMPLE_WIDTH_DEF = 32;

	// Slope fraction scale, 1/100000 units
	localparam logic [16:0] FRAC_SCALE = 17'd100000;

	// x / 100000 == (x >> 5) / 3125; the second step is a reciprocal multiply
	localparam int          RECIP_PRE   = 5;
	localparam int          RECIP_SHIFT = 39;
	localparam logic [27:0] RECIP_MULT  = 28'd175921861;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_VALUE_LOW  = 2'd0;
	localparam logic [1:0] REG_RAW_LOW    = 2'd1;
	localparam logic [1:0] REG_VALUE_HIGH = 2'd2;
	localparam logic [1:0] REG_RAW_HIGH   = 2'd3;

	// Calibration points as written over the register port
	typedef struct packed {
		logic signed [DATA_W-1:0] value_low;
		logic signed [DATA_W-1:0] raw_low;
		logic signed [DATA_W-1:0] value_high;
		logic signed [DATA_W-1:0] raw_high;
	} cal_t;

	// Derived coefficients and their status
	typedef struct packed {
		logic                     valid;
		logic                     error;
		logic signed [DATA_W-1:0] whole;
		logic signed [FRAC_W-1:0] fraction;
		logic signed [DATA_W-1:0] offset;
	} coef_t;

endpackage

>>> rtl/two_point_linear_calibration.sv
// Two-point linear calibration: register port, coefficient sequencer and
// a five-stage sample pipeline. Uses tplc_pkg and tplc_coef.
//
// One sample is taken per clock once the coefficients are ready and the output
// is not stalled; a stalled output holds the full stages of the pipeline while
// empty ones still fill. After reset and after every register write the
// coefficients are derived again (up to three divisions in a shared divider
// plus setup and finish steps, two divisions when the slope
// saturates), during which s_tready is low. The user must see that registers are
// written only while no transaction is in flight; the block does not enforce it.
module two_point_linear_calibration #(
	parameter int SAMPLE_WIDTH = tplc_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// register port
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [tplc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// sample in
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [31:0]                s_tdata,   // [31:0] raw_sample
	// result out
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [119:0]               m_tdata,   // [31:0] calibrated, [63:32] slope_whole,
	                                              // [81:64] slope_fraction, [113:82] offset
	output logic                       m_tuser    // [0] degenerate
);
	import tplc_pkg::*;

	cal_t  cal_q;
	coef_t coef;
	logic  cfg_wr;

	logic signed [SAMPLE_WIDTH-1:0] x_in;
	logic signed [DATA_W-1:0]       frac_ext;
	logic [RECIP_SHIFT+15:0]        recip_prod;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                     rdy1, rdy2, rdy3, rdy4, rdy5;
	logic signed [DATA_W-1:0] x_s1;
	logic [DATA_W-1:0]        mw_s2, mf_s2;
	logic [DATA_W-1:0]        sum_s3, mag_s3;
	logic                     neg_s3;
	logic [DATA_W-1:0]        sum_s4;
	logic [15:0]              q_s4;
	logic                     neg_s4;
	logic [DATA_W-1:0]        calib_s5;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_VALUE_LOW:  cal_q.value_low  <= pwdata;
				REG_RAW_LOW:    cal_q.raw_low    <= pwdata;
				REG_VALUE_HIGH: cal_q.value_high <= pwdata;
				REG_RAW_HIGH:   cal_q.raw_high   <= pwdata;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_VALUE_LOW:  prdata = cal_q.value_low;
			REG_RAW_LOW:    prdata = cal_q.raw_low;
			REG_VALUE_HIGH: prdata = cal_q.value_high;
			REG_RAW_HIGH:   prdata = cal_q.raw_high;
		endcase
	end

	// Coefficient derivation
	tplc_coef u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (cfg_wr),
		.cal     (cal_q),
		.coef    (coef)
	);

	// Per-stage advance: a stage takes new data when empty or when it drains
	assign rdy5     = !v_s5 || m_tready;
	assign rdy4     = !v_s4 || rdy5;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign s_tready = coef.valid && rdy1;

	assign x_in       = s_tdata[SAMPLE_WIDTH-1:0];
	assign frac_ext   = DATA_W'(coef.fraction);
	assign recip_prod = mag_s3[DATA_W-1:RECIP_PRE] * RECIP_MULT;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid && s_tready;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// Data stages
	always_ff @(posedge clk) begin
		// s1: sign-extended sample
		if (rdy1) x_s1 <= DATA_W'(x_in);
		// s2: wrapping products with slope and fraction
		if (rdy2) begin
			mw_s2 <= DATA_W'(x_s1 * coef.whole);
			mf_s2 <= DATA_W'(x_s1 * frac_ext);
		end
		// s3: magnitude of fraction product, offset added to whole product
		if (rdy3) begin
			neg_s3 <= mf_s2[DATA_W-1];
			mag_s3 <= mf_s2[DATA_W-1] ? -mf_s2 : mf_s2;
			sum_s3 <= mw_s2 + coef.offset;
		end
		// s4: truncating divide by 100000 via reciprocal
		if (rdy4) begin
			q_s4   <= recip_prod[RECIP_SHIFT+15:RECIP_SHIFT];
			neg_s4 <= neg_s3;
			sum_s4 <= sum_s3;
		end
		// s5: signed quotient into the sum
		if (rdy5) begin
			calib_s5 <= sum_s4 + (neg_s4 ? -DATA_W'(q_s4) : DATA_W'(q_s4));
		end
	end

	assign m_tvalid = v_s5;
	assign m_tdata  = {6'b0, coef.offset, coef.fraction, coef.whole, calib_s5};
	assign m_tuser  = coef.error;

`ifndef ASSERT_OFF
	a_ready_needs_coef: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> coef.valid)
		else $error("sample accepted without derived coefficients");

	a_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> !coef.valid)
		else $error("register write did not restart derivation");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(coef.valid && coef.error) |->
		(coef.whole == '0 && coef.fraction == '0 && coef.offset == '0))
		else $error("degenerate calibration with nonzero coefficients");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		coef.valid |-> (coef.fraction < 18'sd100000 && coef.fraction > -18'sd100000))
		else $error("slope fraction out of range");

	a_coef_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && coef.valid && !cfg_wr) |=> $stable(coef.whole))
		else $error("coefficients changed under a pending result");
`endif

endmodule

>>> rtl/tplc_coef.sv
// Coefficient derivation sequencer: two 32x32 products, a shared radix-2
// restoring divider with a 64-bit dividend and 32-bit saturation. Uses tplc_pkg.
module tplc_coef (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           restart,
	input  tplc_pkg::cal_t cal,
	output tplc_pkg::coef_t coef
);
	import tplc_pkg::*;

	localparam logic [3:0] ST_READY = 4'd0;
	localparam logic [3:0] ST_DIFF  = 4'd1;
	localparam logic [3:0] ST_MULA  = 4'd2;
	localparam logic [3:0] ST_MULB  = 4'd3;
	localparam logic [3:0] ST_SUB   = 4'd4;
	localparam logic [3:0] ST_LOADW = 4'd5;
	localparam logic [3:0] ST_DIVW  = 4'd6;
	localparam logic [3:0] ST_FRAC  = 4'd7;
	localparam logic [3:0] ST_DIVF  = 4'd8;
	localparam logic [3:0] ST_OFFS  = 4'd9;
	localparam logic [3:0] ST_DIVB  = 4'd10;
	localparam logic [3:0] ST_FIN   = 4'd11;

	localparam logic [5:0] DIV_LAST = 6'd63;

	logic [3:0]         state_q;
	logic signed [32:0] n_q, d_q;
	logic signed [63:0] prod_a_q, prod_b_q;
	logic signed [64:0] p_q;
	logic [63:0]        p_mag_q;
	logic               p_neg_q, q_neg_q;
	logic [32:0]        den_q;
	logic [63:0]        num_q;
	logic [33:0]        rem_q;
	logic [5:0]         cnt_q;
	logic signed [31:0] whole_q, offset_q;
	logic signed [17:0] frac_q;
	logic               err_q, valid_q;

	logic [33:0] rem_sh;
	logic [34:0] rem_diff;
	logic        rem_ge;
	logic [33:0] rem_nxt;
	logic [63:0] num_nxt;
	logic [32:0] n_mag, d_mag;
	logic [64:0] p_neg_val;
	logic [32:0] sat_w, sat_b;

	// Saturate a magnitude and sign to 32-bit two's complement; MSB flags a clip
	function automatic logic [32:0] sat32(input logic [63:0] mag, input logic neg);
		logic [32:0] r;
		if (!neg) begin
			if (mag > 64'h0000_0000_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
			else r = {1'b0, mag[31:0]};
		end else begin
			if (mag > 64'h0000_0000_8000_0000) r = {1'b1, 32'h8000_0000};
			else r = {1'b0, -mag[31:0]};
		end
		return r;
	endfunction

	// One restoring-division step: quotient bits shift into num
	always_comb begin
		rem_sh   = {rem_q[32:0], num_q[63]};
		rem_diff = {1'b0, rem_sh} - {2'b00, den_q};
		rem_ge   = !rem_diff[34];
		rem_nxt  = rem_ge ? rem_diff[33:0] : rem_sh;
		num_nxt  = {num_q[62:0], rem_ge};
	end

	// Magnitudes and saturated quotients
	always_comb begin
		n_mag     = n_q[32] ? 33'(-n_q) : 33'(n_q);
		d_mag     = d_q[32] ? 33'(-d_q) : 33'(d_q);
		p_neg_val = -p_q;
		sat_w     = sat32(num_q, q_neg_q);
		sat_b     = sat32(num_q, p_neg_q);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_DIFF;
			valid_q  <= 1'b0;
			err_q    <= 1'b0;
			whole_q  <= '0;
			frac_q   <= '0;
			offset_q <= '0;
		end else if (restart) begin
			state_q <= ST_DIFF;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_READY: begin
					state_q <= ST_READY;
				end
				ST_DIFF: begin
					state_q <= ST_MULA;
				end
				ST_MULA: begin
					err_q <= (d_q == '0);
					if (n_q == '0 || d_q == '0) begin
						whole_q  <= '0;
						frac_q   <= '0;
						offset_q <= '0;
						valid_q  <= 1'b1;
						state_q  <= ST_READY;
					end else begin
						state_q <= ST_MULB;
					end
				end
				ST_MULB:  state_q <= ST_SUB;
				ST_SUB:   state_q <= ST_LOADW;
				ST_LOADW: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (cnt_q == DIV_LAST) state_q <= ST_FRAC;
				end
				ST_FRAC: begin
					whole_q <= sat_w[31:0];
					if (sat_w[32]) begin
						frac_q  <= '0;
						state_q <= ST_DIVB;
					end else begin
						state_q <= ST_DIVF;
					end
				end
				ST_DIVF: begin
					if (cnt_q == DIV_LAST) state_q <= ST_OFFS;
				end
				ST_OFFS: begin
					frac_q  <= q_neg_q ? -$signed(num_q[17:0]) : $signed(num_q[17:0]);
					state_q <= ST_DIVB;
				end
				ST_DIVB: begin
					if (cnt_q == DIV_LAST) state_q <= ST_FIN;
				end
				ST_FIN: begin
					offset_q <= sat_b[31:0];
					valid_q  <= 1'b1;
					state_q  <= ST_READY;
				end
				default: state_q <= ST_DIFF;
			endcase
		end
	end

	// Datapath registers (no reset)
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DIFF: begin
				n_q <= 33'(cal.value_low) - 33'(cal.value_high);
				d_q <= 33'(cal.raw_low) - 33'(cal.raw_high);
			end
			ST_MULA: begin
				prod_a_q <= $signed(cal.value_high) * $signed(cal.raw_low);
				den_q    <= d_mag;
				q_neg_q  <= n_q[32] ^ d_q[32];
			end
			ST_MULB: begin
				prod_b_q <= $signed(cal.value_low) * $signed(cal.raw_high);
			end
			ST_SUB: begin
				p_q <= 65'(prod_a_q) - 65'(prod_b_q);
			end
			ST_LOADW: begin
				p_mag_q <= p_q[64] ? p_neg_val[63:0] : p_q[63:0];
				p_neg_q <= p_q[64] ^ d_q[32];
				num_q   <= 64'(n_mag);
				rem_q   <= '0;
				cnt_q   <= '0;
			end
			ST_DIVW, ST_DIVF, ST_DIVB: begin
				num_q <= num_nxt;
				rem_q <= rem_nxt;
				cnt_q <= cnt_q + 6'd1;
			end
			ST_FRAC: begin
				num_q <= sat_w[32] ? p_mag_q : 64'(rem_q[32:0] * FRAC_SCALE);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_OFFS: begin
				num_q <= p_mag_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	assign coef.valid    = valid_q;
	assign coef.error    = err_q;
	assign coef.whole    = whole_q;
	assign coef.fraction = frac_q;
	assign coef.offset   = offset_q;

endmodule

>>> tb/sv/tplc_calibration_checker.sv
// Checker for two_point_linear_calibration: mirrors the calibration registers,
// fits the line on the first sample after a register change and compares each result and read.
// Depends on tplc_pkg for the register indexes, the calibration point type and field widths.
module tplc_calibration_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tplc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	input  logic                        s_tvalid,
	input  logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // [31:0] raw_sample
	input  logic                        m_tvalid,
	input  logic                        m_tready,
	input  logic [119:0]                m_tdata,   // [31:0] calibrated, [63:32] slope_whole,
	                                               // [81:64] slope_fraction, [113:82] offset
	input  logic                        m_tuser,   // [0] degenerate
	output int                          pending,
	output int                          errors
);
	import tplc_pkg::*;

	localparam int     FRACTION_UNITS = 100000;
	localparam longint WORD_MAX       = 64'sd2147483647;
	localparam longint WORD_MIN       = -64'sd2147483648;

	typedef struct packed {
		logic [31:0]       calibrated;
		logic [31:0]       slope_whole;
		logic [FRAC_W-1:0] slope_fraction;
		logic [31:0]       offset;
		logic              degenerate;
	} calibration_t;

	// register mirror and coefficients in use
	cal_t         points;
	logic [31:0]  slope_whole_q;
	logic [31:0]  slope_frac_q;
	logic [31:0]  offset_q;
	logic         line_fitted;
	logic         degenerate_q;
	calibration_t awaited_calibrations[$];

	// line through the two points, truncated toward zero and clamped to 32 bits
	function automatic void fit_line();
		longint vl, rl, vh, rh, num, den, whole, frac, offs;
		vl = points.value_low;
		rl = points.raw_low;
		vh = points.value_high;
		rh = points.raw_high;
		num = vl - vh;
		den = rl - rh;
		whole = 0;
		frac = 0;
		offs = 0;
		degenerate_q = (den == 0);
		if (num != 0 && den != 0) begin
			whole = num / den;
			// a clamped slope carries no fraction
			if (whole > WORD_MAX)
				whole = WORD_MAX;
			else if (whole < WORD_MIN)
				whole = WORD_MIN;
			else
				frac = ((num % den) * FRACTION_UNITS) / den;
			offs = (vh * rl - vl * rh) / den;
			if (offs > WORD_MAX)
				offs = WORD_MAX;
			else if (offs < WORD_MIN)
				offs = WORD_MIN;
		end
		slope_whole_q = whole[31:0];
		slope_frac_q  = frac[31:0];
		offset_q      = offs[31:0];
		line_fitted   = 1'b1;
	endfunction

	// sample*whole + (sample*fraction)/100000 + offset, all wrapping at 32 bits
	function automatic calibration_t calibrate_sample(logic [31:0] sample);
		calibration_t r;
		logic [31:0]  frac_prod;
		int           part;
		frac_prod = sample * slope_frac_q;
		part = $signed(frac_prod) / FRACTION_UNITS;
		r.calibrated     = sample * slope_whole_q + part + offset_q;
		r.slope_whole    = slope_whole_q;
		r.slope_fraction = slope_frac_q[FRAC_W-1:0];
		r.offset         = offset_q;
		r.degenerate     = degenerate_q;
		return r;
	endfunction

	task automatic compare_word(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		calibration_t want;
		if (!arst_n) begin
			points        = '0;
			slope_whole_q = '0;
			slope_frac_q  = '0;
			offset_q      = '0;
			line_fitted   = 1'b0;
			degenerate_q  = 1'b0;
			awaited_calibrations.delete();
			pending = 0;
			errors  = 0;
		end else begin
			// register port: writes force a new fit, reads are checked against the mirror
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[3:2])
						REG_VALUE_LOW:  points.value_low  = pwdata;
						REG_RAW_LOW:    points.raw_low    = pwdata;
						REG_VALUE_HIGH: points.value_high = pwdata;
						REG_RAW_HIGH:   points.raw_high   = pwdata;
					endcase
					line_fitted = 1'b0;
				end else begin
					case (paddr[3:2])
						REG_VALUE_LOW:  compare_word("value_low read", points.value_low, prdata);
						REG_RAW_LOW:    compare_word("raw_low read", points.raw_low, prdata);
						REG_VALUE_HIGH: compare_word("value_high read", points.value_high, prdata);
						REG_RAW_HIGH:   compare_word("raw_high read", points.raw_high, prdata);
					endcase
				end
			end

			// result transaction against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (awaited_calibrations.size() == 0) begin
					errors++;
					$display("%0t: result with none expected: actual %h user %b",
						$time, m_tdata, m_tuser);
				end else begin
					want = awaited_calibrations.pop_front();
					compare_word("calibrated", want.calibrated, m_tdata[31:0]);
					compare_word("slope_whole", want.slope_whole, m_tdata[63:32]);
					compare_word("slope_fraction", 32'(want.slope_fraction), 32'(m_tdata[81:64]));
					compare_word("offset", want.offset, m_tdata[113:82]);
					compare_word("degenerate", 32'(want.degenerate), 32'(m_tuser));
				end
			end

			// sample transaction
			if (s_tvalid && s_tready) begin
				if (!line_fitted)
					fit_line();
				awaited_calibrations.push_back(calibrate_sample(s_tdata));
			end

			pending = awaited_calibrations.size();
		end
	end

endmodule

>>> tb/sv/tb_two_point_linear_calibration.sv
// Testbench top for two_point_linear_calibration: clock, reset, register writes and reads,
// sample stream and result ready with random pacing, a watchdog, and the final verdict.
// Depends on tplc_pkg, the block itself and tplc_calibration_checker.
module tb_two_point_linear_calibration;
	import tplc_pkg::*;

	localparam int RANDOM_ITEMS = 1550;
	localparam int CALM_ITEMS   = 250;
	localparam int STUCK_LIMIT  = 2000;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                psel     = 1'b0;
	logic                penable  = 1'b0;
	logic                pwrite   = 1'b0;
	logic [ADDR_W-1:0]   paddr    = '0;
	logic [31:0]         pwdata   = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [31:0]         s_tdata  = '0;   // [31:0] raw_sample
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [119:0]        m_tdata;         // [31:0] calibrated, [63:32] slope_whole,
	                                      // [81:64] slope_fraction, [113:82] offset
	logic                m_tuser;         // [0] degenerate

	int   pending;
	int   errors;
	bit   calm;
	int   src_idle_pct;
	int   sink_stall_pct;
	cal_t cur_points;

	always #1 clk = ~clk;

	two_point_linear_calibration i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	tplc_calibration_checker i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.pending  (pending),
		.errors   (errors)
	);

	// one register transaction: setup phase, then access phase until pready
	task automatic reg_access(input bit is_write, input logic [1:0] idx,
			input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= is_write;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
	endtask

	// write the selected points, then read all four back
	task automatic set_points(input logic [31:0] vl, rl, vh, rh, input logic [3:0] mask);
		if (mask[0]) begin
			cur_points.value_low = vl;
			reg_access(1'b1, REG_VALUE_LOW, vl);
		end
		if (mask[1]) begin
			cur_points.raw_low = rl;
			reg_access(1'b1, REG_RAW_LOW, rl);
		end
		if (mask[2]) begin
			cur_points.value_high = vh;
			reg_access(1'b1, REG_VALUE_HIGH, vh);
		end
		if (mask[3]) begin
			cur_points.raw_high = rh;
			reg_access(1'b1, REG_RAW_HIGH, rh);
		end
		reg_access(1'b0, REG_VALUE_LOW, '0);
		reg_access(1'b0, REG_RAW_LOW, '0);
		reg_access(1'b0, REG_VALUE_HIGH, '0);
		reg_access(1'b0, REG_RAW_HIGH, '0);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// offer one sample, possibly after an idle burst; returns at the falling edge after it is taken
	task automatic send_sample(input logic [31:0] sample);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sample;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drop valid and wait for every calibrated result to come back
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom;
			4, 5:       return $urandom_range(0, 2000) - 1000;
			6:          return pick_extreme();
			7, 8:       return cur_points.raw_low + $urandom_range(0, 20) - 10;
			default:    return cur_points.raw_high + $urandom_range(0, 20) - 10;
		endcase
	endfunction

	function automatic cal_t pick_points();
		cal_t p;
		p.value_low  = $urandom;
		p.raw_low    = $urandom;
		p.value_high = $urandom;
		p.raw_high   = $urandom;
		case ($urandom_range(0, 6))
			// moderate span: real fractions, no slope clamping
			0, 1: begin
				p.value_low  = $urandom_range(0, 2000000) - 1000000;
				p.value_high = $urandom_range(0, 2000000) - 1000000;
				p.raw_low    = $urandom_range(0, 10000) - 5000;
				p.raw_high   = $urandom_range(0, 10000) - 5000;
			end
			// raw readings at most three counts apart: steep slope, large offset, degenerate if equal
			2: p.raw_high = p.raw_low + $urandom_range(0, 6) - 3;
			3: p.raw_high = p.raw_low;
			4: p.value_high = p.value_low;
			5: begin
				p.value_low  = pick_extreme();
				p.raw_low    = pick_extreme();
				p.value_high = pick_extreme();
				p.raw_high   = pick_extreme();
			end
			default: ;
		endcase
		return p;
	endfunction

	// ready pacing on the result side
	initial begin : sink_pacing
		int hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				m_tready <= 1'b0;
				hold--;
			end else if (!calm && sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
				m_tready <= 1'b0;
				hold = $urandom_range(1, 9) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// give up after a long stretch with no transaction anywhere
	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STUCK_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
				stuck = 0;
			else
				stuck++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		int   sent;
		int   count;
		cal_t p;
		logic [3:0] mask;
		sent           = 0;
		calm           = 1'b0;
		src_idle_pct   = 20;
		sink_stall_pct = 20;
		cur_points     = '0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset points: raw readings equal, so degenerate with zero coefficients
		send_sample(32'h0000_0000);
		send_sample(32'h0000_0001);
		send_sample(32'hFFFF_FFFF);
		drain();

		// equal values: zero coefficients, not degenerate
		set_points(32'd500, 32'd10, 32'd500, 32'd2000, 4'hF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		drain();

		// equal raw readings with different values
		set_points(32'd100, 32'd7, -32'd300, 32'd7, 4'hF);
		send_sample(32'd12345);
		send_sample(32'h8000_0000);
		drain();

		// slope 33333.33333: whole and fraction both in use
		set_points(32'd0, 32'd0, 32'd100000, 32'd3, 4'hF);
		send_sample(32'd3);
		send_sample(-32'd3);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'h8000_0000);
		drain();

		// negative slope with a fraction
		set_points(32'd1000, -32'd7, -32'd2001, 32'd13, 4'hF);
		send_sample(32'd13);
		send_sample(-32'd7);
		send_sample(32'd99999);
		drain();

		// slope clamped high, then low; fraction forced to zero
		set_points(32'h7FFF_FFFF, 32'd1, 32'h8000_0000, 32'd0, 4'hF);
		send_sample(32'd1);
		send_sample(32'h8000_0000);
		drain();
		set_points(32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 32'd0, 4'hF);
		send_sample(32'd2);
		send_sample(32'h7FFF_FFFF);
		drain();

		// offset clamped low, then high
		set_points(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFE, 4'hF);
		send_sample(32'h7FFF_FFFE);
		send_sample(32'h0000_0000);
		drain();
		set_points(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFE, 4'hF);
		send_sample(32'h7FFF_FFFF);
		send_sample(32'hFFFF_FFFF);
		drain();

		// both points identical
		set_points(32'd42, 32'd5, 32'd42, 32'd5, 4'hF);
		send_sample(32'd5);
		drain();

		// raw readings at opposite ends of the range
		set_points(32'd0, 32'h8000_0000, 32'd1, 32'h7FFF_FFFF, 4'hF);
		send_sample(32'h8000_0000);
		send_sample(32'h7FFF_FFFF);
		drain();

		// random calibrations, each followed by a batch of samples
		while (sent < RANDOM_ITEMS) begin
			calm = (sent >= RANDOM_ITEMS - CALM_ITEMS);
			if (calm) begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0:       src_idle_pct = 0;
					1:       src_idle_pct = 10;
					default: src_idle_pct = 35;
				endcase
				case ($urandom_range(0, 3))
					0:       sink_stall_pct = 0;
					1:       sink_stall_pct = 10;
					default: sink_stall_pct = 35;
				endcase
			end
			p = pick_points();
			mask = 4'hF;
			if ($urandom_range(0, 2) == 0) begin
				mask = 4'($urandom_range(1, 15));
			end
			set_points(p.value_low, p.raw_low, p.value_high, p.raw_high, mask);
			count = $urandom_range(1, 60);
			repeat (count) begin
				send_sample(pick_sample());
				sent++;
			end
			drain();
		end

		// let the pipeline settle, then report
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

>>> sim.f
rtl/tplc_pkg.sv
rtl/tplc_coef.sv
rtl/two_point_linear_calibration.sv
tb/sv/tplc_calibration_checker.sv
tb/sv/tb_two_point_linear_calibration.sv
